// ===== rtl/xcrc_pkg.sv =====
// Shared types, constants and the CRC-16 byte update for the XMODEM-CRC receiver.
package xcrc_pkg;

    localparam int GROUP_PACKETS_DEF = 8;
    localparam int PAYLOAD_BYTES     = 128;
    localparam int OFF_W             = $clog2(PAYLOAD_BYTES);

    localparam logic [7:0]  FRAME_BYTES   = 8'd133;
    localparam logic [7:0]  PAYLOAD_FIRST = 8'd3;
    localparam logic [7:0]  PAYLOAD_LAST  = 8'd130;
    localparam logic [7:0]  CRC_HI_POS    = 8'd131;
    localparam logic [7:0]  POS_MAX       = 8'd255;
    localparam logic [7:0]  SOH_BYTE      = 8'h01;
    localparam logic [7:0]  EOT_BYTE      = 8'h04;
    localparam logic [15:0] CRC_POLY      = 16'h1021;

    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_BYTE  = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    localparam logic [1:0] REPLY_NONE = 2'd0;
    localparam logic [1:0] REPLY_ACK  = 2'd1;
    localparam logic [1:0] REPLY_NAK  = 2'd2;

    // First member sits in the highest bits, so the list runs from the top field down.
    typedef struct packed {
        logic [7:0]  read_data;
        logic        receiving;
        logic        poll_active;
        logic [15:0] packets_accepted;
        logic        session_done;
        logic [10:0] write_length;
        logic [31:0] write_address;
        logic        write_request;
        logic [1:0]  reply;
    } result_t;

    // CRC-16/XMODEM update over one byte, MSB first.
    function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ===== rtl/xcrc_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module xcrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/xmodem_crc_receiver_top.sv =====
// Top level of the XMODEM-CRC receiver: frame parsing, CRC check and packet group buffer.
//
//  Channel   Direction  Handshake              Contents
//  s_        in         s_tvalid / s_tready    tuser: action; tdata: data byte, read index;
//                                              tlast: frame end
//  m_        out        m_tvalid / m_tready    tdata: one status/result word per input word
//  cfg_      in         cfg_valid / cfg_ready  region base address (32 bits)
//
// The block takes one input word per clock cycle while the output is not stalled. Each
// accepted word produces exactly one result word: the group buffer RAM read is registered
// together with stage p, and the result then moves to the output register. An output
// register and a stage before it let the next word enter while a finished result still
// waits on m_tready; s_tready drops only when both stages are full and m_tready is low.
// Reset clears all frame, session and counter state and the per-slot bank bits. The group
// buffer itself is not cleared; a byte that was never written reads as an unknown value.
// Configuration writes are always accepted.
//
// The buffer holds two banks per packet slot. Payload bytes are written straight into the
// bank that is not committed for the current slot; a packet with a good CRC flips that
// slot's bank bit, so a failed or malformed frame never disturbs committed data.
module xmodem_crc_receiver_top #(
    parameter int GROUP_PACKETS = xcrc_pkg::GROUP_PACKETS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] data_byte, [17:8] read_index, [23:18] zero
    input  logic [1:0]  s_tuser,   // [1:0] action
    input  logic        s_tlast,   // frame_end

    output logic        m_tvalid,
    input  logic        m_tready,
    // [1:0] reply, [2] write_request, [34:3] write_address, [45:35] write_length,
    // [46] session_done, [62:47] packets_accepted, [63] poll_active, [64] receiving,
    // [72:65] read_data, [79:73] zero
    output logic [79:0] m_tdata,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data   // region_base_address
);

    localparam int SLOT_W   = (GROUP_PACKETS > 1) ? $clog2(GROUP_PACKETS) : 1;
    localparam int NSLOT    = 1 << SLOT_W;
    localparam int AW       = 1 + SLOT_W + xcrc_pkg::OFF_W;
    localparam int DEPTH    = 1 << AW;
    localparam logic [31:0] GROUP_BYTES = 32'(GROUP_PACKETS * xcrc_pkg::PAYLOAD_BYTES);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(GROUP_PACKETS - 1);

    // Input word fields.
    logic [1:0] in_action;
    logic [7:0] in_byte;
    logic [9:0] in_ridx;
    logic       accept;

    assign in_action = s_tuser;
    assign in_byte   = s_tdata[7:0];
    assign in_ridx   = s_tdata[17:8];

    // Configuration.
    logic [31:0] base_reg;
    assign cfg_ready = 1'b1;

    // Frame and session state.
    logic [15:0]       crc_reg, crc_next;
    logic [7:0]        pos_reg, pos_next;
    logic [7:0]        first_reg, first_next;
    logic [7:0]        sent_hi_reg, sent_hi_next;
    logic [15:0]       pc_reg, pc_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [31:0]       goff_reg, goff_next;
    logic [NSLOT-1:0]  bank_reg, bank_next;
    logic              session_reg, session_next;
    logic              poll_reg, poll_next;

    // Pipeline: stage p waits for the RAM read, stage o is the output register.
    logic                 p_valid_reg, p_valid_next;
    logic                 o_valid_reg, o_valid_next;
    xcrc_pkg::result_t    p_res_reg, res;
    logic                 p_rd_reg;
    xcrc_pkg::result_t    o_res_reg;
    logic                 p_adv;

    // RAM ports.
    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [7:0]        ram_rdata;

    // Read address decode.
    logic [9:0]        rd_hi;
    logic [SLOT_W-1:0] rd_slot;
    logic              rd_in_range;

    logic [7:0]        len;
    logic              crc_ok;

    assign p_adv    = !o_valid_reg || m_tready;
    assign s_tready = !p_valid_reg || p_adv;
    assign accept   = s_tvalid && s_tready;

    assign rd_hi       = in_ridx >> xcrc_pkg::OFF_W;
    assign rd_slot     = rd_hi[SLOT_W-1:0];
    assign rd_in_range = 32'(in_ridx) < GROUP_BYTES;
    assign ram_raddr   = {bank_reg[rd_slot], rd_slot, in_ridx[xcrc_pkg::OFF_W-1:0]};
    assign ram_re      = accept && (in_action == xcrc_pkg::ACT_READ) && rd_in_range;

    assign ram_waddr = {~bank_reg[slot_reg], slot_reg,
                        xcrc_pkg::OFF_W'(pos_reg - xcrc_pkg::PAYLOAD_FIRST)};

    assign len    = (pos_reg == xcrc_pkg::POS_MAX) ? xcrc_pkg::POS_MAX : 8'(pos_reg + 8'd1);
    assign crc_ok = crc_reg == {sent_hi_reg, in_byte};

    always_comb begin
        crc_next     = crc_reg;
        pos_next     = pos_reg;
        first_next   = first_reg;
        sent_hi_next = sent_hi_reg;
        pc_next      = pc_reg;
        slot_next    = slot_reg;
        goff_next    = goff_reg;
        bank_next    = bank_reg;
        session_next = session_reg;
        poll_next    = poll_reg;
        ram_we       = 1'b0;
        res          = '0;

        if (accept) begin
            case (in_action)
                xcrc_pkg::ACT_START: begin
                    session_next = 1'b1;
                    poll_next    = 1'b1;
                    pc_next      = '0;
                    slot_next    = '0;
                    goff_next    = '0;
                    crc_next     = '0;
                    pos_next     = '0;
                    first_next   = '0;
                    sent_hi_next = '0;
                end
                xcrc_pkg::ACT_BYTE: begin
                    if (session_reg) begin
                        if (pos_reg == 8'd0) begin
                            first_next = in_byte;
                        end
                        if (pos_reg >= xcrc_pkg::PAYLOAD_FIRST &&
                            pos_reg <= xcrc_pkg::PAYLOAD_LAST) begin
                            crc_next = xcrc_pkg::crc16_byte(crc_reg, in_byte);
                            ram_we   = 1'b1;
                        end else if (pos_reg == xcrc_pkg::CRC_HI_POS) begin
                            sent_hi_next = in_byte;
                        end
                        pos_next = len;

                        if (s_tlast) begin
                            if (len == xcrc_pkg::FRAME_BYTES && first_reg == xcrc_pkg::SOH_BYTE) begin
                                poll_next = 1'b0;
                                if (crc_ok) begin
                                    res.reply           = xcrc_pkg::REPLY_ACK;
                                    bank_next[slot_reg] = ~bank_reg[slot_reg];
                                    pc_next             = 16'(pc_reg + 16'd1);
                                    if (pc_reg == 16'hFFFF || slot_reg == SLOT_LAST) begin
                                        // The group is full (or the counter wrapped to zero).
                                        res.write_request = 1'b1;
                                        res.write_address = base_reg + goff_reg;
                                        res.write_length  = GROUP_BYTES[10:0];
                                        slot_next         = '0;
                                        goff_next         = (pc_reg == 16'hFFFF) ? 32'd0
                                                                : goff_reg + GROUP_BYTES;
                                    end else begin
                                        slot_next = SLOT_W'(slot_reg + 1'b1);
                                    end
                                end else begin
                                    res.reply = xcrc_pkg::REPLY_NAK;
                                end
                            end else if (len == 8'd1 && in_byte == xcrc_pkg::EOT_BYTE) begin
                                res.reply = xcrc_pkg::REPLY_ACK;
                                if (slot_reg != '0) begin
                                    res.write_request = 1'b1;
                                    res.write_address = base_reg + goff_reg;
                                    res.write_length  = 11'({slot_reg, {xcrc_pkg::OFF_W{1'b0}}});
                                end
                                session_next     = 1'b0;
                                poll_next        = 1'b0;
                                res.session_done = 1'b1;
                            end
                            crc_next     = '0;
                            pos_next     = '0;
                            first_next   = '0;
                            sent_hi_next = '0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        res.packets_accepted = pc_next;
        res.poll_active      = poll_next;
        res.receiving        = session_next;

        p_valid_next = accept ? 1'b1 : (p_adv ? 1'b0 : p_valid_reg);
        o_valid_next = (p_valid_reg && p_adv) ? 1'b1 : (m_tready ? 1'b0 : o_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg    <= '0;
            crc_reg     <= '0;
            pos_reg     <= '0;
            first_reg   <= '0;
            sent_hi_reg <= '0;
            pc_reg      <= '0;
            slot_reg    <= '0;
            goff_reg    <= '0;
            bank_reg    <= '0;
            session_reg <= 1'b0;
            poll_reg    <= 1'b0;
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                base_reg <= cfg_data;
            end
            crc_reg     <= crc_next;
            pos_reg     <= pos_next;
            first_reg   <= first_next;
            sent_hi_reg <= sent_hi_next;
            pc_reg      <= pc_next;
            slot_reg    <= slot_next;
            goff_reg    <= goff_next;
            bank_reg    <= bank_next;
            session_reg <= session_next;
            poll_reg    <= poll_next;
            p_valid_reg <= p_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    // Payload registers: loaded on the handshakes, no reset needed.
    always_ff @(posedge aclk) begin
        if (accept) begin
            p_res_reg <= res;
            p_rd_reg  <= ram_re;
        end
        if (p_valid_reg && p_adv) begin
            o_res_reg           <= p_res_reg;
            o_res_reg.read_data <= p_rd_reg ? ram_rdata : 8'd0;
        end
    end

    xcrc_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_buf (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (in_byte),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = {7'd0, o_res_reg};

`ifndef SYNTH
    // A flash write is only ever requested together with an ACK.
    a_write_needs_ack: assert property (@(posedge aclk) disable iff (!aresetn)
        o_valid_reg && o_res_reg.write_request |-> o_res_reg.reply == xcrc_pkg::REPLY_ACK)
        else $error("write request without ACK");

    // Ending the session leaves neither the session nor polling active.
    a_done_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        o_valid_reg && o_res_reg.session_done |-> !o_res_reg.receiving && !o_res_reg.poll_active)
        else $error("session_done with session still open");

    // The input side stalls only when both stages hold a word and the output is blocked.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> p_valid_reg && o_valid_reg && !m_tready)
        else $error("input stalled with room in the pipeline");

    // A payload write never lands in the committed bank of its slot.
    a_write_bank: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> ram_waddr[AW-1] != bank_reg[slot_reg])
        else $error("payload write into committed bank");
`endif

endmodule
